[rtl/core/zigzag_row_transposer_core_defines.svh]
// Assertion macros shared by the zigzag row transposer RTL.
`ifndef ZIGZAG_ROW_TRANSPOSER_CORE_DEFINES_SVH
`define ZIGZAG_ROW_TRANSPOSER_CORE_DEFINES_SVH

// Condition a implies condition c in the same cycle.
`define ZRT_ASSERT_NOW(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition a implies condition c in the following cycle.
`define ZRT_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[rtl/core/zrt_pkg.sv]
// Shared types and constants for the zigzag row transposer.
`timescale 1ns / 1ps

package zrt_pkg;

  localparam int DATA_W          = 8;
  localparam int ROWS_W          = 7;
  localparam int MAX_LEN_DEFAULT = 64;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } zrt_state_t;

endpackage

[rtl/core/zigzag_row_transposer_core.sv]
// Zigzag (rail-fence) row transposer: buffers one message and replays it rail by rail.
//
// Input: an item is taken when start is high and busy is low; it carries one
// message byte (char_in) and a flag on the final byte (is_last). Each byte is
// written to the message memory; bytes past MAX_LEN are dropped and the run
// that follows is marked truncated.
// On the final byte the block raises busy and reads the memory once per cycle
// in rail-fence order, one read per stored byte. Results appear in the cycle
// after their read, on char_out, last_out and truncated, each marked by valid
// for exactly one cycle; the first result follows the final byte through the
// control state and output registers, and the last one carries last_out. The
// single memory read port sets the replay rate of one byte per cycle; loading
// is one byte per cycle while start is held, and no byte is taken during
// replay. The receiver cannot stall, so results are never held.
// The rail count is written through cfg_write / cfg_data; the user must write
// it only while the block is idle, which the block itself does not enforce. A
// value of zero acts as one rail. Reset clears the byte count, the overflow
// flag and the control state and sets the rail count to one; the memory is
// not cleared, since only entries written for the current message are read.
`timescale 1ns / 1ps
`include "zigzag_row_transposer_core_defines.svh"

module zigzag_row_transposer_core
  import zrt_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] char_in,
  input  logic              is_last,
  input  logic              cfg_write,
  input  logic [ROWS_W-1:0] cfg_data,
  output logic              valid,
  output logic [DATA_W-1:0] char_out,
  output logic              last_out,
  output logic              truncated
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = ROWS_W + 1;
  localparam int SW = ((CW > PW) ? CW : PW) + 1;

  logic [DATA_W-1:0] mem [MAX_LEN];

  zrt_state_t        state, state_next;
  logic [ROWS_W-1:0] num_rows;
  logic [CW-1:0]     byte_count, byte_count_next;
  logic              overflow_seen, overflow_seen_next;
  logic [CW-1:0]     msg_len, msg_len_next;
  logic              msg_trunc, msg_trunc_next;
  logic [ROWS_W-1:0] rail, rail_next;
  logic [AW-1:0]     pos, pos_next;
  logic              phase, phase_next;
  logic [CW-1:0]     emit_cnt, emit_cnt_next;
  logic              valid_next;
  logic              last_out_next;

  logic              accept;
  logic              buf_full;
  logic              wr_en;
  logic              rd_en;
  logic [ROWS_W-1:0] rows_eff;
  logic [PW-1:0]     period;
  logic [PW-1:0]     two_r;
  logic [PW-1:0]     step;
  logic              edge_rail;
  logic [SW-1:0]     pos_sum;
  logic              rail_done;
  logic              run_end;

  assign busy     = (state == ST_EMIT);
  assign accept   = start && !busy;
  assign buf_full = (byte_count == CW'(MAX_LEN));
  assign wr_en    = accept && !buf_full;
  assign rd_en    = (state == ST_EMIT);

  // Rail r holds positions r, P-r, P+r, 2P-r, ... with period P = 2(R-1);
  // the top and bottom rails step by the full period.
  assign rows_eff  = (num_rows == '0) ? ROWS_W'(1) : num_rows;
  assign period    = {rows_eff - ROWS_W'(1), 1'b0};
  assign two_r     = {rail, 1'b0};
  assign edge_rail = (rail == '0) || (rail == rows_eff - ROWS_W'(1));
  assign pos_sum   = SW'(pos) + SW'(step);
  assign rail_done = (pos_sum >= SW'(msg_len));
  assign run_end   = (emit_cnt == msg_len - CW'(1));

  always_comb begin
    if (rows_eff == ROWS_W'(1)) begin
      step = PW'(1);
    end else if (edge_rail) begin
      step = period;
    end else if (phase) begin
      step = two_r;
    end else begin
      step = period - two_r;
    end
  end

  always_comb begin
    state_next         = state;
    byte_count_next    = byte_count;
    overflow_seen_next = overflow_seen;
    msg_len_next       = msg_len;
    msg_trunc_next     = msg_trunc;
    rail_next          = rail;
    pos_next           = pos;
    phase_next         = phase;
    emit_cnt_next      = emit_cnt;
    valid_next         = 1'b0;
    last_out_next      = last_out;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!buf_full) begin
            byte_count_next = byte_count + CW'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          if (is_last) begin
            msg_len_next       = buf_full ? byte_count : byte_count + CW'(1);
            msg_trunc_next     = overflow_seen || buf_full;
            byte_count_next    = '0;
            overflow_seen_next = 1'b0;
            rail_next          = '0;
            pos_next           = '0;
            phase_next         = 1'b0;
            emit_cnt_next      = '0;
            state_next         = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        valid_next    = 1'b1;
        last_out_next = run_end;
        emit_cnt_next = emit_cnt + CW'(1);
        if (rail_done) begin
          rail_next  = rail + ROWS_W'(1);
          pos_next   = AW'(rail + ROWS_W'(1));
          phase_next = 1'b0;
        end else begin
          pos_next   = pos_sum[AW-1:0];
          phase_next = !phase;
        end
        if (run_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
      num_rows      <= ROWS_W'(1);
      valid         <= 1'b0;
    end else begin
      state         <= state_next;
      byte_count    <= byte_count_next;
      overflow_seen <= overflow_seen_next;
      valid         <= valid_next;
      if (cfg_write) begin
        num_rows <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    msg_len   <= msg_len_next;
    msg_trunc <= msg_trunc_next;
    rail      <= rail_next;
    pos       <= pos_next;
    phase     <= phase_next;
    emit_cnt  <= emit_cnt_next;
    last_out  <= last_out_next;
    if (rd_en) begin
      truncated <= msg_trunc;
    end
  end

  // Message memory: one write port for loading, one registered read port for replay.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[byte_count[AW-1:0]] <= char_in;
    end
    if (rd_en) begin
      char_out <= mem[pos];
    end
  end

  `ZRT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, byte_count <= CW'(MAX_LEN),
    "byte count exceeds buffer capacity")
  `ZRT_ASSERT_NOW(a_emit_in_range, clk, rst, state == ST_EMIT,
    (emit_cnt < msg_len) && (CW'(pos) < msg_len), "replay read beyond stored message")
  `ZRT_ASSERT_NEXT(a_single_last, clk, rst, valid && last_out, !valid,
    "result follows the end of a run")
  `ZRT_ASSERT_NEXT(a_emit_valid, clk, rst, state == ST_EMIT, valid,
    "replay read produced no result")

endmodule
